@@ sv/bilateral_image_filter_core_assert.svh @@
// Assertion macros for the bilateral filter checker.
// Expects clk_i and rst_ni in the scope of use.
`ifndef BILATERAL_IMAGE_FILTER_CORE_ASSERT_SVH
`define BILATERAL_IMAGE_FILTER_CORE_ASSERT_SVH

// cons must hold in the cycle after ante
`define BIF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bif: assertion failed");

// a stalled beat keeps valid and payload
`define BIF_ASSERT_HOLD(lbl, vld, stl, dat) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && stl) |=> (vld && $stable(dat))) \
    else $error("bif: stalled beat changed");

`endif

@@ sv/bif_pkg.sv @@
// Shared types, codes and constants of the bilateral filter.
// No dependencies.
package bif_pkg;

  localparam int MAX_RADIUS = 3;
  localparam int LINES      = 2 * MAX_RADIUS + 1;
  localparam int TAPS       = LINES * LINES;
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int LS_DEPTH   = LINES * MAX_WIDTH;
  localparam int LS_AW      = 14;
  localparam int NUM_W      = 30;
  localparam int DEN_W      = 22;
  localparam int CFG_W      = 13;

  localparam logic [1:0] OP_PIXEL   = 2'd0;
  localparam logic [1:0] OP_FLUSH   = 2'd1;
  localparam logic [1:0] OP_RANGE   = 2'd2;
  localparam logic [1:0] OP_SPATIAL = 2'd3;

  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CENTRE, ST_CAPT, ST_TAPS, ST_DRAIN, ST_DIV, ST_OUT
  } bif_state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  pixel_value;
    logic [7:0]  table_index;
    logic [15:0] weight_value;
  } bif_in_t;

  typedef struct packed {
    logic [7:0]  filtered_pixel;
    logic [11:0] out_row;
    logic [10:0] out_col;
    logic        frame_end;
  } bif_out_t;

  typedef struct packed {
    logic take;
    logic centre_rd;
    logic centre_cap;
    logic tap_issue;
    logic div_start;
    logic div_step;
    logic out_load;
  } bif_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic last_tap;
    logic pipe_busy;
    logic div_last;
    logic out_free;
  } bif_stat_t;

  // v stays below 21
  function automatic logic [2:0] mod7(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (r >= 5'd14) begin
      r = r - 5'd14;
    end else if (r >= 5'd7) begin
      r = r - 5'd7;
    end
    return r[2:0];
  endfunction

endpackage

@@ sv/bif_ctrl.sv @@
// Sequencer of the bilateral filter: item intake, tap sweep, divide, result.
// Uses bif_pkg.
module bif_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  bif_pkg::bif_stat_t  stat_i,
  output bif_pkg::bif_cmd_t   cmd_o,
  output logic                in_stall_o
);

  bif_pkg::bif_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bif_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      bif_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
        if (in_valid_i && stat_i.emit_req) begin
          state_d = bif_pkg::ST_CENTRE;
        end
      end
      bif_pkg::ST_CENTRE: begin
        cmd_o.centre_rd = 1'b1;
        state_d         = bif_pkg::ST_CAPT;
      end
      bif_pkg::ST_CAPT: begin
        cmd_o.centre_cap = 1'b1;
        state_d          = bif_pkg::ST_TAPS;
      end
      bif_pkg::ST_TAPS: begin
        cmd_o.tap_issue = 1'b1;
        if (stat_i.last_tap) begin
          state_d = bif_pkg::ST_DRAIN;
        end
      end
      bif_pkg::ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          cmd_o.div_start = 1'b1;
          state_d         = bif_pkg::ST_DIV;
        end
      end
      bif_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = bif_pkg::ST_OUT;
        end
      end
      bif_pkg::ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = bif_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bif_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/bif_datapath.sv @@
// Datapath of the bilateral filter: registers, frame counters, line store,
// weight tables, tap pipeline, restoring divider, result register. Uses bif_pkg.
module bif_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [bif_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  bif_pkg::bif_in_t              in_data_i,
  input  bif_pkg::bif_cmd_t             cmd_i,
  output bif_pkg::bif_stat_t            stat_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bif_pkg::bif_out_t             out_data_o
);

  // configuration
  logic [1:0]  radius_q;
  logic [11:0] width_q;
  logic [12:0] height_q;
  logic        cfg_restart;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 2'd1;
      width_q  <= 12'd640;
      height_q <= 13'd480;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bif_pkg::CFG_RADIUS: radius_q <= cfg_wdata_i[1:0];
        bif_pkg::CFG_WIDTH:  width_q  <= cfg_wdata_i[11:0];
        bif_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  assign cfg_restart = cfg_we_i && (cfg_idx_i == bif_pkg::CFG_RADIUS ||
                       cfg_idx_i == bif_pkg::CFG_WIDTH || cfg_idx_i == bif_pkg::CFG_HEIGHT);

  logic [11:0] eff_w;
  logic [12:0] eff_h;
  logic [23:0] total;
  logic [13:0] lag;
  logic [2:0]  span;

  always_comb begin
    if (width_q == 12'd0) begin
      eff_w = 12'd1;
    end else if (width_q > 12'(bif_pkg::MAX_WIDTH)) begin
      eff_w = 12'(bif_pkg::MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
    if (height_q == 13'd0) begin
      eff_h = 13'd1;
    end else if (height_q > 13'(bif_pkg::MAX_HEIGHT)) begin
      eff_h = 13'(bif_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height_q;
    end
  end

  assign total = 24'(eff_w) * 24'(eff_h);
  assign lag   = 14'(14'(radius_q) * 14'(eff_w)) + 14'(radius_q);
  assign span  = {radius_q, 1'b0};

  // frame bookkeeping
  logic [10:0] in_col_q, in_col_d, em_col_q, em_col_d;
  logic [11:0] in_row_q, in_row_d, em_row_q, em_row_d;
  logic [2:0]  in_ring_q, in_ring_d, em_ring_q, em_ring_d;
  logic [22:0] in_idx_q, in_idx_d, em_cnt_q, em_cnt_d;
  logic        full_q, full_d;

  logic        is_pix, restart_pix;
  logic [10:0] p_col, b_col;
  logic [11:0] p_row, b_row;
  logic [2:0]  p_ring, b_ring;
  logic [22:0] p_idx, b_cnt;
  logic        emit, last;

  assign is_pix      = in_data_i.opcode == bif_pkg::OP_PIXEL;
  assign restart_pix = is_pix && full_q;
  assign p_col  = restart_pix ? '0 : in_col_q;
  assign p_row  = restart_pix ? '0 : in_row_q;
  assign p_ring = restart_pix ? '0 : in_ring_q;
  assign p_idx  = restart_pix ? '0 : in_idx_q;
  assign b_col  = restart_pix ? '0 : em_col_q;
  assign b_row  = restart_pix ? '0 : em_row_q;
  assign b_ring = restart_pix ? '0 : em_ring_q;
  assign b_cnt  = restart_pix ? '0 : em_cnt_q;

  always_comb begin
    if (is_pix) begin
      emit = (24'(p_idx) >= 24'(lag)) && (24'(b_cnt) + 24'(lag) <= 24'(p_idx));
    end else if (in_data_i.opcode == bif_pkg::OP_FLUSH) begin
      emit = full_q && (24'(em_cnt_q) < total);
    end else begin
      emit = 1'b0;
    end
  end

  assign last = (b_row == 12'(eff_h - 13'd1)) && (b_col == 11'(eff_w - 12'd1));

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    in_ring_d = in_ring_q;
    in_idx_d  = in_idx_q;
    full_d    = full_q;
    em_col_d  = em_col_q;
    em_row_d  = em_row_q;
    em_ring_d = em_ring_q;
    em_cnt_d  = em_cnt_q;
    if (cfg_restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      in_ring_d = '0;
      in_idx_d  = '0;
      full_d    = 1'b0;
      em_col_d  = '0;
      em_row_d  = '0;
      em_ring_d = '0;
      em_cnt_d  = '0;
    end else if (cmd_i.take) begin
      if (is_pix) begin
        em_col_d  = b_col;
        em_row_d  = b_row;
        em_ring_d = b_ring;
        em_cnt_d  = b_cnt;
        full_d    = 1'b0;
        if ({1'b0, p_col} + 12'd1 >= eff_w) begin
          in_col_d = '0;
          if ({1'b0, p_row} + 13'd1 >= eff_h) begin
            in_row_d  = '0;
            in_ring_d = '0;
            in_idx_d  = '0;
            full_d    = 1'b1;
          end else begin
            in_row_d  = p_row + 12'd1;
            in_ring_d = (p_ring == 3'(bif_pkg::LINES - 1)) ? 3'd0 : p_ring + 3'd1;
            in_idx_d  = p_idx + 23'd1;
          end
        end else begin
          in_col_d  = p_col + 11'd1;
          in_row_d  = p_row;
          in_ring_d = p_ring;
          in_idx_d  = p_idx + 23'd1;
        end
      end
      if (emit) begin
        if (last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          in_ring_d = '0;
          in_idx_d  = '0;
          full_d    = 1'b0;
          em_col_d  = '0;
          em_row_d  = '0;
          em_ring_d = '0;
          em_cnt_d  = '0;
        end else begin
          em_cnt_d = b_cnt + 23'd1;
          if ({1'b0, b_col} + 12'd1 >= eff_w) begin
            em_col_d  = '0;
            em_row_d  = b_row + 12'd1;
            em_ring_d = (b_ring == 3'(bif_pkg::LINES - 1)) ? 3'd0 : b_ring + 3'd1;
          end else begin
            em_col_d  = b_col + 11'd1;
            em_row_d  = b_row;
            em_ring_d = b_ring;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_ring_q <= '0;
      in_idx_q  <= '0;
      full_q    <= 1'b0;
      em_col_q  <= '0;
      em_row_q  <= '0;
      em_ring_q <= '0;
      em_cnt_q  <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      in_ring_q <= in_ring_d;
      in_idx_q  <= in_idx_d;
      full_q    <= full_d;
      em_col_q  <= em_col_d;
      em_row_q  <= em_row_d;
      em_ring_q <= em_ring_d;
      em_cnt_q  <= em_cnt_d;
    end
  end

  // position of the output being worked on
  logic [11:0] cr_q;
  logic [10:0] cc_q;
  logic [2:0]  cring_q;
  logic        fend_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && emit) begin
      cr_q    <= b_row;
      cc_q    <= b_col;
      cring_q <= b_ring;
      fend_q  <= last;
    end
  end

  // tap counters
  logic [2:0] ti_q, tj_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ti_q <= '0;
      tj_q <= '0;
    end else if (cmd_i.centre_rd) begin
      ti_q <= '0;
      tj_q <= '0;
    end else if (cmd_i.tap_issue) begin
      if (tj_q == span) begin
        tj_q <= '0;
        ti_q <= ti_q + 3'd1;
      end else begin
        tj_q <= tj_q + 3'd1;
      end
    end
  end

  // tap address
  logic [12:0] rsum;
  logic [11:0] csum;
  logic        row_ok, col_ok;
  logic [10:0] tcol;
  logic [2:0]  tring;
  logic [5:0]  tidx;
  logic [bif_pkg::LS_AW-1:0] rd_addr, wr_addr;

  assign rsum   = {1'b0, cr_q} + 13'(ti_q);
  assign csum   = {1'b0, cc_q} + 12'(tj_q);
  assign row_ok = (rsum >= 13'(radius_q)) && (14'(rsum) < 14'(eff_h) + 14'(radius_q));
  assign col_ok = (csum >= 12'(radius_q)) && (13'(csum) < 13'(eff_w) + 13'(radius_q));
  assign tcol   = 11'(csum - 12'(radius_q));
  assign tring  = bif_pkg::mod7(5'(cring_q) + 5'(ti_q) + 5'(bif_pkg::LINES) - 5'(radius_q));
  assign tidx   = 6'({ti_q, 3'b000}) - 6'(ti_q) + 6'(tj_q);
  assign rd_addr = cmd_i.centre_rd ? {cring_q, cc_q} : {tring, tcol};
  assign wr_addr = {p_ring, p_col};

  // line store: ring of line buffers
  logic [7:0] ls_mem [bif_pkg::LS_DEPTH];
  logic [7:0] ls_rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && is_pix) begin
      ls_mem[wr_addr] <= in_data_i.pixel_value;
    end
    ls_rdata_q <= ls_mem[rd_addr];
  end

  logic [7:0] centre_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.centre_cap) begin
      centre_q <= ls_rdata_q;
    end
  end

  // tap pipeline
  logic       v1_q, v2_q, v3_q, v4_q;
  logic       inb1_q;
  logic [5:0] tidx1_q;
  logic [7:0] px1, diff, px2_q, px3_q;
  logic [15:0] rw_q, sw_q, wt, wt_q;
  logic [31:0] prod_q;
  logic [23:0] wp_q;
  logic [bif_pkg::NUM_W-1:0] num_q;
  logic [bif_pkg::DEN_W-1:0] den_q;

  assign px1  = inb1_q ? ls_rdata_q : 8'd0;
  assign diff = (px1 > centre_q) ? px1 - centre_q : centre_q - px1;
  assign wt   = prod_q[31:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.tap_issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    inb1_q  <= row_ok && col_ok;
    tidx1_q <= tidx;
    px2_q   <= px1;
    prod_q  <= 32'(sw_q) * 32'(rw_q);
    px3_q   <= px2_q;
    wp_q    <= 24'(wt) * 24'(px3_q);
    wt_q    <= wt;
    if (cmd_i.centre_rd) begin
      num_q <= '0;
      den_q <= '0;
    end else if (v4_q) begin
      num_q <= num_q + bif_pkg::NUM_W'(wp_q);
      den_q <= den_q + bif_pkg::DEN_W'(wt_q);
    end
  end

  // weight tables
  logic [15:0] rng_mem [256];
  logic [15:0] sp_mem  [bif_pkg::TAPS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && in_data_i.opcode == bif_pkg::OP_RANGE) begin
      rng_mem[in_data_i.table_index] <= in_data_i.weight_value;
    end
    rw_q <= rng_mem[diff];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && in_data_i.opcode == bif_pkg::OP_SPATIAL &&
        in_data_i.table_index < 8'(bif_pkg::TAPS)) begin
      sp_mem[in_data_i.table_index[5:0]] <= in_data_i.weight_value;
    end
    sw_q <= sp_mem[tidx1_q];
  end

  // restoring divider, one quotient bit a cycle
  logic [bif_pkg::NUM_W-1:0] rem_q;
  logic [7:0]  quo_q;
  logic [2:0]  bit_q;
  logic        dz_q;
  logic [bif_pkg::NUM_W:0] shifted;

  assign shifted = (bif_pkg::NUM_W + 1)'(den_q) << bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= num_q;
      quo_q <= '0;
      bit_q <= 3'd7;
      dz_q  <= den_q == '0;
    end else if (cmd_i.div_step) begin
      if ({1'b0, rem_q} >= shifted) begin
        rem_q        <= rem_q - bif_pkg::NUM_W'(shifted);
        quo_q[bit_q] <= 1'b1;
      end
      bit_q <= bit_q - 3'd1;
    end
  end

  // result register
  logic out_valid_q;
  bif_pkg::bif_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.filtered_pixel <= dz_q ? 8'd0 : quo_q;
      out_q.out_row        <= cr_q;
      out_q.out_col        <= cc_q;
      out_q.frame_end      <= fend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.emit_req  = emit;
  assign stat_o.last_tap  = (ti_q == span) && (tj_q == span);
  assign stat_o.pipe_busy = v1_q || v2_q || v3_q || v4_q;
  assign stat_o.div_last  = bit_q == 3'd0;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

@@ sv/bilateral_image_filter_core.sv @@
// Table writes, flushes and pixels that release no output leave the sequencer in IDLE.
// An item that releases an output is worked through the single tap pipeline (one tap
// a cycle) and the 8-step restoring divider before its result is loaded.
// Throughput: one such item at a time; the next item is taken while the result waits.
// Reset: asynchronous, active low; R=1, W=640, H=480, frame counters cleared.
// Line store and weight tables are not cleared and hold garbage until written.
module bilateral_image_filter_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration writes
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [bif_pkg::CFG_W-1:0]  cfg_wdata_i,
  // input beats
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bif_pkg::bif_in_t           in_data_i,
  // result beats
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bif_pkg::bif_out_t          out_data_o
);

  // Controller sequences each released output: centre read, tap sweep,
  // pipeline drain, divide, then load of the result register.
  bif_pkg::bif_cmd_t  cmd;
  bif_pkg::bif_stat_t stat;

  bif_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Datapath holds the 7-line ring store, both weight tables, the tap
  // pipeline (read, table lookup, weight product, pixel product, sum)
  // and the divider. The result register parts the output from the core.
  bif_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sv/bif_checker.sv @@
// Port-level checks of the bilateral filter, bound to the top level.
// Uses bif_pkg and bilateral_image_filter_core_assert.svh.
`include "bilateral_image_filter_core_assert.svh"

module bif_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input bif_pkg::bif_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input bif_pkg::bif_out_t out_data_o
);

  `BIF_ASSERT_HOLD(a_out_hold, out_valid_o, out_stall_i, out_data_o)
  `BIF_ASSERT_NEXT(a_table_write_quick, in_valid_i && !in_stall_o && (in_data_i.opcode == bif_pkg::OP_RANGE || in_data_i.opcode == bif_pkg::OP_SPATIAL), !in_stall_o)
  `BIF_ASSERT_NEXT(a_new_result_idle, out_valid_o && !out_stall_i, !out_valid_o || !in_stall_o)

endmodule

bind bilateral_image_filter_core bif_checker u_bif_checker (.*);

@@ tb/tb.sv @@
// Self-checking testbench for bilateral_image_filter_core: directed table, then random frames.
// Predicts every output beat in-line and compares it with the block's result beats.
// Depends on bif_pkg and the core RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DIR_N       = 10;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [1:0]                cfg_idx_i = bif_pkg::CFG_RADIUS;
  logic [bif_pkg::CFG_W-1:0] cfg_wdata_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  bif_pkg::bif_in_t          in_data_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  bif_pkg::bif_out_t         out_data_o;

  bilateral_image_filter_core u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]  pix_mem [bif_pkg::LINES][bif_pkg::MAX_WIDTH];
  logic [15:0] rng_wt [256];
  logic [15:0] spa_wt [bif_pkg::TAPS];
  int unsigned cur_row, cur_col, n_emitted;
  bit          frame_done;
  int unsigned radius_q = 1, width_q = 640, height_q = 480;

  bif_pkg::bif_out_t pending_px [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned n_sent = 0;
  int unsigned n_pred = 0;
  bit          hold_rx = 1'b0;
  bit          hold_long = 1'b0;

  function automatic int unsigned eff_w();
    return (width_q == 0) ? 1 :
           ((width_q > bif_pkg::MAX_WIDTH) ? bif_pkg::MAX_WIDTH : width_q);
  endfunction
  function automatic int unsigned eff_h();
    return (height_q == 0) ? 1 :
           ((height_q > bif_pkg::MAX_HEIGHT) ? bif_pkg::MAX_HEIGHT : height_q);
  endfunction

  function automatic void frame_restart();
    cur_row = 0; cur_col = 0; n_emitted = 0; frame_done = 0;
  endfunction

  function automatic logic [7:0] bilateral_at(int unsigned r, int unsigned c);
    int unsigned w, h, rad, centre, px, diff;
    longint unsigned num, den, wt;
    int rr, cc;
    w = eff_w(); h = eff_h(); rad = radius_q;
    centre = pix_mem[r % bif_pkg::LINES][c];
    num = 0; den = 0;
    for (int i = 0; i <= 2 * rad; i++) begin
      for (int j = 0; j <= 2 * rad; j++) begin
        rr = int'(r) + i - int'(rad);
        cc = int'(c) + j - int'(rad);
        px = 0;
        if (rr >= 0 && cc >= 0 && rr < int'(h) && cc < int'(w)) begin
          px = pix_mem[rr % bif_pkg::LINES][cc];
        end
        diff = (px > centre) ? px - centre : centre - px;
        wt = (longint'(spa_wt[i * bif_pkg::LINES + j]) * longint'(rng_wt[diff])) >> 16;
        num += wt * px;
        den += wt;
      end
    end
    if (den == 0) return 8'd0;
    return 8'(num / den);
  endfunction

  function automatic void emit_px();
    bif_pkg::bif_out_t o;
    int unsigned w, total;
    w = eff_w(); total = w * eff_h();
    o.filtered_pixel = bilateral_at(n_emitted / w, n_emitted % w);
    o.out_row = 12'(n_emitted / w);
    o.out_col = 11'(n_emitted % w);
    n_emitted++;
    o.frame_end = (n_emitted >= total);
    pending_px.push_back(o);
    n_pred++;
    if (n_emitted >= total) frame_restart();
  endfunction

  // one accepted beat into the predictor
  function automatic void predict_beat(bif_pkg::bif_in_t b);
    int unsigned w, total, idx, lag;
    w = eff_w(); total = w * eff_h();
    case (b.opcode)
      bif_pkg::OP_RANGE: rng_wt[b.table_index] = b.weight_value;
      bif_pkg::OP_SPATIAL: if (b.table_index < bif_pkg::TAPS) spa_wt[b.table_index] = b.weight_value;
      bif_pkg::OP_FLUSH: if (frame_done && n_emitted < total) emit_px();
      default: begin
        if (frame_done) frame_restart();
        idx = cur_row * w + cur_col;
        pix_mem[cur_row % bif_pkg::LINES][cur_col] = b.pixel_value;
        cur_col++;
        if (cur_col >= w) begin
          cur_col = 0;
          cur_row++;
          if (cur_row >= eff_h()) begin
            cur_row = 0;
            frame_done = 1;
          end
        end
        lag = radius_q * w + radius_q;
        if (idx >= lag && n_emitted + lag <= idx) emit_px();
      end
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    bif_pkg::bif_out_t e;
    if (rst_ni) cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_px.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected beat %p", out_data_o);
      end else begin
        e = pending_px.pop_front();
        if (out_data_o.filtered_pixel !== e.filtered_pixel || out_data_o.out_row !== e.out_row
            || out_data_o.out_col !== e.out_col || out_data_o.frame_end !== e.frame_end) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("mismatch: exp %p got %p", e, out_data_o);
        end
      end
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stall pattern, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_long) begin
      out_stall_i <= 1'b1;
    end else if (hold_rx) begin
      out_stall_i <= ($urandom_range(3) == 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    forever begin
      wait (hold_long);
      repeat (400) @(posedge clk_i);
      hold_long = 1'b0;
    end
  end

  task automatic send_beat(bif_pkg::bif_in_t b);
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_beat(b);
    n_sent++;
    // random gap after a burst
    if ($urandom_range(7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    in_valid_i  <= 1'b0;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= bif_pkg::CFG_W'(val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      bif_pkg::CFG_RADIUS: radius_q = val & 3;
      bif_pkg::CFG_WIDTH:  width_q  = val & 12'hFFF;
      default:             height_q = val & 13'h1FFF;
    endcase
    frame_restart();
  endtask

  function automatic bif_pkg::bif_in_t mk(logic [1:0] op, logic [7:0] pv, logic [7:0] ti,
                                          logic [15:0] wv);
    bif_pkg::bif_in_t b;
    b.opcode = op; b.pixel_value = pv; b.table_index = ti; b.weight_value = wv;
    return b;
  endfunction

  task automatic load_tables(bit rnd);
    for (int i = 0; i < 256; i++)
      send_beat(mk(bif_pkg::OP_RANGE, 8'($urandom), 8'(i), rnd ? 16'($urandom) : 16'hFFFF));
    for (int i = 0; i < bif_pkg::TAPS; i++)
      send_beat(mk(bif_pkg::OP_SPATIAL, 8'($urandom), 8'(i), rnd ? 16'($urandom) : 16'hFFFF));
  endtask

  task automatic run_frame(int unsigned w, int unsigned h);
    int unsigned n_fl;
    n_fl = radius_q * w + radius_q + 2;
    for (int unsigned k = 0; k < w * h; k++)
      send_beat(mk(bif_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 16'($urandom)));
    for (int unsigned k = 0; k < n_fl; k++)
      send_beat(mk(bif_pkg::OP_FLUSH, 8'($urandom), 8'($urandom), 16'($urandom)));
  endtask

  // directed beats on a 3x2 frame, R=0: each output is its own pixel
  bif_pkg::bif_in_t dir_tab [DIR_N];
  logic [7:0]       dir_exp [DIR_N];
  bit               dir_chk [DIR_N];

  initial begin
    int unsigned iter;
    int unsigned n_before;
    frame_restart();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_tables(0);
    write_reg(bif_pkg::CFG_WIDTH, 3);
    write_reg(bif_pkg::CFG_HEIGHT, 2);
    write_reg(bif_pkg::CFG_RADIUS, 0);
    dir_tab[0] = mk(bif_pkg::OP_PIXEL, 8'h00, 8'h00, 16'h0000);   dir_exp[0] = 8'h00;
    dir_tab[1] = mk(bif_pkg::OP_PIXEL, 8'hFF, 8'h00, 16'h0000);   dir_exp[1] = 8'hFF;
    dir_tab[2] = mk(bif_pkg::OP_PIXEL, 8'h01, 8'h00, 16'h0000);   dir_exp[2] = 8'h01;
    dir_tab[3] = mk(bif_pkg::OP_SPATIAL, 8'h00, 8'hFF, 16'h0000); dir_exp[3] = 8'h00;
    dir_tab[4] = mk(bif_pkg::OP_PIXEL, 8'hFE, 8'h00, 16'h0000);   dir_exp[4] = 8'hFE;
    dir_tab[5] = mk(bif_pkg::OP_PIXEL, 8'h80, 8'h00, 16'h0000);   dir_exp[5] = 8'h80;
    dir_tab[6] = mk(bif_pkg::OP_PIXEL, 8'h07, 8'h00, 16'h0000);   dir_exp[6] = 8'h07;
    dir_tab[7] = mk(bif_pkg::OP_FLUSH, 8'h00, 8'h00, 16'h0000);   dir_exp[7] = 8'h00;
    dir_tab[8] = mk(bif_pkg::OP_PIXEL, 8'h55, 8'h00, 16'h0000);   dir_exp[8] = 8'h55;
    dir_tab[9] = mk(bif_pkg::OP_RANGE, 8'h00, 8'h00, 16'hFFFF);   dir_exp[9] = 8'h00;
    // out-of-range tap write, empty flush and table write release nothing
    dir_chk = '{1, 1, 1, 0, 1, 1, 1, 0, 1, 0};
    for (int i = 0; i < DIR_N; i++) begin
      n_before = n_pred;
      send_beat(dir_tab[i]);
      if (dir_chk[i]) begin
        if (n_pred != n_before + 1) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("row %0d: exp %0h got no output", i, dir_exp[i]);
        end else begin
          pending_px[$].filtered_pixel = dir_exp[i];
        end
      end else if (n_pred != n_before) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("row %0d: exp no output", i);
      end
    end
    wait_drained();
    write_reg(bif_pkg::CFG_RADIUS, 1);
    run_frame(3, 2);
    wait_drained();
    // zero weight sum gives zero
    for (int i = 0; i < bif_pkg::TAPS; i++)
      send_beat(mk(bif_pkg::OP_SPATIAL, 8'h00, 8'(i), 16'h0000));
    write_reg(bif_pkg::CFG_RADIUS, 0);
    run_frame(2, 2);
    wait_drained();
    for (int i = 0; i < bif_pkg::TAPS; i++)
      send_beat(mk(bif_pkg::OP_SPATIAL, 8'($urandom), 8'(i), 16'($urandom)));
    hold_rx = 1'b1;

    iter = 0;
    while (n_sent < 760) begin
      for (int k = 0; k < 6; k++)
        send_beat(mk(bif_pkg::OP_RANGE, 8'($urandom), 8'($urandom), 16'($urandom)));
      for (int k = 0; k < 2; k++)
        send_beat(mk(bif_pkg::OP_SPATIAL, 8'($urandom), 8'($urandom_range(63)),
                     16'($urandom)));
      write_reg(bif_pkg::CFG_RADIUS, $urandom_range(3));
      if (iter == 2) begin
        // big enough frame to back up behind a long receiver hold-off
        write_reg(bif_pkg::CFG_WIDTH, 8);
        write_reg(bif_pkg::CFG_HEIGHT, 6);
        hold_long = 1'b1;
      end else begin
        write_reg(bif_pkg::CFG_WIDTH, $urandom_range(1, 12));
        write_reg(bif_pkg::CFG_HEIGHT, $urandom_range(1, 8));
      end
      run_frame(eff_w(), eff_h());
      // once in a while, start a new frame with one pixel and leave it unfinished
      if ($urandom_range(3) == 0)
        send_beat(mk(bif_pkg::OP_PIXEL, 8'($urandom), 8'h00, 16'h0000));
      wait_drained();
      iter++;
    end
    // out-of-range registers once, then back to a small frame
    write_reg(bif_pkg::CFG_WIDTH, 4095);
    write_reg(bif_pkg::CFG_HEIGHT, 8191);
    write_reg(bif_pkg::CFG_RADIUS, 3);
    for (int k = 0; k < 40; k++)
      send_beat(mk(bif_pkg::OP_PIXEL, 8'($urandom), 8'h00, 16'h0000));
    write_reg(bif_pkg::CFG_HEIGHT, 1);
    write_reg(bif_pkg::CFG_WIDTH, 1);
    run_frame(1, 1);
    wait_drained();
    if (mismatch_cnt == 0 && pending_px.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ bilateral_image_filter_core.f @@
+incdir+sv
sv/bif_pkg.sv
sv/bif_ctrl.sv
sv/bif_datapath.sv
sv/bilateral_image_filter_core.sv
sv/bif_checker.sv
tb/tb.sv
